// ----- rtl/lvil_pkg.sv -----
// ----------------------------------------------------------------------------
// lvil_pkg
// Shared constants, types and codes of the linear velocity integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package lvil_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int SQRT_ITERATIONS = 32;
  localparam int SQRT_STEPS      = (SQRT_ITERATIONS < 32) ? SQRT_ITERATIONS : 32;
  localparam int SQRT_SHIFT      = 32 - SQRT_STEPS;
  localparam int DT_FRAC         = 16;
  localparam int DIV_STEPS       = 64;
  localparam int CNT_W           = 6;
  localparam int PADDR_W         = 5;

  localparam logic [31:0] DAMP_Q32 = 32'd4282082394;
  // Z speed limit of 1500 at the chosen fraction width, kept wide so that it
  // simply never triggers when it does not fit the velocity word.
  localparam logic signed [63:0] Z_LIMIT_WIDE = 64'sd1500 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    REG_INV_MASS   = 3'd0,
    REG_STEP_TIME  = 3'd1,
    REG_MIN_Z_ACC  = 3'd2,
    REG_MAX_Z_RISE = 3'd3,
    REG_MAX_HSPEED = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]        inverse_mass;
    logic [15:0]        step_time;
    logic signed [31:0] min_z_accel;
    logic [30:0]        max_z_rise;
    logic [30:0]        max_horizontal_speed;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_ACC,
    PH_INC,
    PH_DAMP
  } phase_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_MAG, DP_MLO, DP_MHI, DP_MFIN, DP_POST, DP_ZLIM,
    DP_SQX, DP_SQY, DP_SQSUM, DP_SQRT, DP_DMUL, DP_DINIT, DP_DIV, DP_DEND,
    DP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    phase_t     phase;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic len_gt;
    logic out_busy;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MAG, S_MLO, S_MHI, S_MFIN, S_POST, S_ZLIM, S_SQX, S_SQY,
    S_SQSUM, S_SQRT, S_CMP, S_DMUL, S_DINIT, S_DIV, S_DEND, S_COMMIT
  } ctrl_state_t;

endpackage

`default_nettype wire

// ----- rtl/lvil_regs.sv -----
// ----------------------------------------------------------------------------
// lvil_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module lvil_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lvil_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output lvil_pkg::cfg_t                   cfg
);
  import lvil_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_mass         <= 32'd65536;
      cfg.step_time            <= 16'd1092;
      cfg.min_z_accel          <= -32'sd72089600;
      cfg.max_z_rise           <= 31'd39321600;
      cfg.max_horizontal_speed <= 31'd65536000;
    end else if (wr_en) begin
      unique case (idx)
        REG_INV_MASS:   cfg.inverse_mass         <= pwdata;
        REG_STEP_TIME:  cfg.step_time            <= pwdata[15:0];
        REG_MIN_Z_ACC:  cfg.min_z_accel          <= pwdata;
        REG_MAX_Z_RISE: cfg.max_z_rise           <= pwdata[30:0];
        REG_MAX_HSPEED: cfg.max_horizontal_speed <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INV_MASS:   prdata = cfg.inverse_mass;
      REG_STEP_TIME:  prdata = {16'd0, cfg.step_time};
      REG_MIN_Z_ACC:  prdata = cfg.min_z_accel;
      REG_MAX_Z_RISE: prdata = {1'b0, cfg.max_z_rise};
      REG_MAX_HSPEED: prdata = {1'b0, cfg.max_horizontal_speed};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/lvil_ctrl.sv -----
// ----------------------------------------------------------------------------
// lvil_ctrl
// Sequencer that steps the datapath through one integration step.
// ----------------------------------------------------------------------------
`default_nettype none

module lvil_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lvil_pkg::dp_status_t status,
  output lvil_pkg::dp_cmd_t         cmd
);
  import lvil_pkg::*;

  ctrl_state_t      state, state_next;
  phase_t           phase, phase_next;
  logic [1:0]       axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_ACC;
      axis  <= 2'd0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    axis_next  = axis;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_MAG;
          phase_next = PH_ACC;
          axis_next  = 2'd0;
        end
      end
      S_MAG:  state_next = S_MLO;
      S_MLO:  state_next = S_MHI;
      S_MHI:  state_next = S_MFIN;
      S_MFIN: state_next = S_POST;
      S_POST: begin
        if (axis != 2'd2) begin
          axis_next  = axis + 2'd1;
          state_next = S_MAG;
        end else begin
          axis_next = 2'd0;
          unique case (phase)
            PH_ACC: begin
              phase_next = PH_INC;
              state_next = S_MAG;
            end
            PH_INC: begin
              phase_next = PH_DAMP;
              state_next = S_MAG;
            end
            default: state_next = S_ZLIM;
          endcase
        end
      end
      S_ZLIM: state_next = S_SQX;
      S_SQX:  state_next = S_SQY;
      S_SQY:  state_next = S_SQSUM;
      S_SQSUM: begin
        cnt_next   = CNT_W'(SQRT_STEPS - 1);
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (cnt == '0) state_next = S_CMP;
        else cnt_next = cnt - 1'b1;
      end
      S_CMP: begin
        axis_next  = 2'd0;
        state_next = status.len_gt ? S_DMUL : S_COMMIT;
      end
      S_DMUL: state_next = S_DINIT;
      S_DINIT: begin
        cnt_next   = CNT_W'(DIV_STEPS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == '0) state_next = S_DEND;
        else cnt_next = cnt - 1'b1;
      end
      S_DEND: begin
        if (axis == 2'd0) begin
          axis_next  = 2'd1;
          state_next = S_DMUL;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!status.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.phase = phase;
    cmd.axis  = axis;
    in_ready  = (state == S_IDLE);
    unique case (state)
      S_IDLE:   cmd.op = in_valid ? DP_LOAD : DP_NOP;
      S_MAG:    cmd.op = DP_MAG;
      S_MLO:    cmd.op = DP_MLO;
      S_MHI:    cmd.op = DP_MHI;
      S_MFIN:   cmd.op = DP_MFIN;
      S_POST:   cmd.op = DP_POST;
      S_ZLIM:   cmd.op = DP_ZLIM;
      S_SQX:    cmd.op = DP_SQX;
      S_SQY:    cmd.op = DP_SQY;
      S_SQSUM:  cmd.op = DP_SQSUM;
      S_SQRT:   cmd.op = DP_SQRT;
      S_DMUL:   cmd.op = DP_DMUL;
      S_DINIT:  cmd.op = DP_DINIT;
      S_DIV:    cmd.op = DP_DIV;
      S_DEND:   cmd.op = DP_DEND;
      S_COMMIT: cmd.op = status.out_busy ? DP_NOP : DP_COMMIT;
      default:  cmd.op = DP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/lvil_dp.sv -----
// ----------------------------------------------------------------------------
// lvil_dp
// Datapath: shared 32x32 multiplier, saturation logic, bit-serial square
// root and restoring divider, velocity state and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lvil_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lvil_pkg::cfg_t     cfg,
  input  wire lvil_pkg::dp_cmd_t  cmd,
  output lvil_pkg::dp_status_t    status,
  input  wire logic signed [47:0] force_x,
  input  wire logic signed [47:0] force_y,
  input  wire logic signed [47:0] force_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      new_vel_x,
  output logic signed [31:0]      new_vel_y,
  output logic signed [31:0]      new_vel_z
);
  import lvil_pkg::*;

  logic signed [47:0] frc [3];
  logic signed [31:0] w   [3];
  logic signed [31:0] vel [3];

  logic [47:0]        mag;
  logic               neg;
  logic [63:0]        prod_lo;
  logic [47:0]        prod_hi;
  logic signed [31:0] r;

  logic [63:0] sq_s;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [31:0] len;

  logic [63:0] dv;
  logic [31:0] dr;

  // Combinational helpers
  logic signed [47:0] a48;
  logic [31:0]        b_sel;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic signed [31:0] wa;
  logic [31:0]        wa_mag;
  logic [79:0]        full, mf_r;
  logic signed [31:0] r_sat;
  logic signed [32:0] inc_sum;
  logic signed [31:0] inc_sat;
  logic signed [31:0] post_val;
  logic signed [33:0] z_diff;
  logic [32:0]        z_cap;
  logic [35:0]        sq_t, sq_trial;
  logic               sq_ge;
  logic [32:0]        dv_t;
  logic               dv_ge;

  assign wa     = w[cmd.axis];
  assign wa_mag = wa[31] ? 32'(-wa) : wa;
  assign a48    = (cmd.phase == PH_ACC) ? frc[cmd.axis] : 48'(wa);
  assign len    = sq_root << SQRT_SHIFT;

  always_comb begin
    unique case (cmd.phase)
      PH_ACC:  b_sel = cfg.inverse_mass;
      PH_INC:  b_sel = {16'd0, cfg.step_time};
      default: b_sel = DAMP_Q32;
    endcase
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    unique case (cmd.op)
      DP_MLO: begin
        mul_a = mag[31:0];
        mul_b = b_sel;
      end
      DP_MHI: begin
        mul_a = {16'd0, mag[47:32]};
        mul_b = b_sel;
      end
      DP_SQX: begin
        mul_a = w[0][31] ? 32'(-w[0]) : w[0];
        mul_b = mul_a;
      end
      DP_SQY: begin
        mul_a = w[1][31] ? 32'(-w[1]) : w[1];
        mul_b = mul_a;
      end
      DP_DMUL: begin
        mul_a = wa_mag;
        mul_b = {1'b0, cfg.max_horizontal_speed};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Product of magnitudes, shifted down and saturated with the sign restored.
  always_comb begin
    full = {prod_hi, 32'd0} + {16'd0, prod_lo};
    unique case (cmd.phase)
      PH_ACC:  mf_r = full >> FRAC_BITS;
      PH_INC:  mf_r = full >> DT_FRAC;
      default: mf_r = full >> 32;
    endcase
    if (neg) begin
      r_sat = (mf_r > 80'h8000_0000) ? 32'sh8000_0000 : 32'(-mf_r[31:0]);
    end else begin
      r_sat = (mf_r > 80'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mf_r[31:0];
    end
  end

  always_comb begin
    inc_sum = 33'(vel[cmd.axis]) + 33'(r);
    if (inc_sum[32] != inc_sum[31]) begin
      inc_sat = inc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      inc_sat = inc_sum[31:0];
    end
    post_val = r;
    unique case (cmd.phase)
      PH_ACC: begin
        if (cmd.axis == 2'd2 && r < cfg.min_z_accel) post_val = cfg.min_z_accel;
      end
      PH_INC: post_val = inc_sat;
      default: begin
        if (cmd.axis == 2'd2) begin
          if (64'(r) > Z_LIMIT_WIDE) post_val = 32'(Z_LIMIT_WIDE);
          else if (64'(r) < -Z_LIMIT_WIDE) post_val = 32'(-Z_LIMIT_WIDE);
        end
      end
    endcase
  end

  assign z_diff   = 34'(w[2]) - 34'(vel[2]);
  assign z_cap    = 33'(vel[2]) + {2'b00, cfg.max_z_rise};
  assign sq_t     = {sq_rem, sq_s[63:62]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign dv_t     = {dr, dv[63]};
  assign dv_ge    = dv_t >= {1'b0, len};

  assign status.len_gt   = len > {1'b0, cfg.max_horizontal_speed};
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        frc[0] <= force_x;
        frc[1] <= force_y;
        frc[2] <= force_z;
      end
      DP_MAG: begin
        neg <= a48[47];
        mag <= a48[47] ? 48'(-a48) : a48;
      end
      DP_MLO:  prod_lo <= mul_p;
      DP_MHI:  prod_hi <= mul_p[47:0];
      DP_MFIN: r <= r_sat;
      DP_POST: w[cmd.axis] <= post_val;
      DP_ZLIM: begin
        if (z_diff > $signed({3'b000, cfg.max_z_rise})) begin
          // The capped sum lies in the signed 33-bit range; only a positive
          // overflow of the 32-bit word needs saturating.
          w[2] <= (z_cap[32:31] == 2'b01) ? 32'sh7FFF_FFFF : z_cap[31:0];
        end
      end
      DP_SQX:  prod_lo <= mul_p;
      DP_SQY: begin
        sq_s    <= prod_lo;
        prod_lo <= mul_p;
      end
      DP_SQSUM: begin
        sq_s    <= sq_s + prod_lo;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      DP_SQRT: begin
        sq_rem  <= sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
        sq_root <= {sq_root[30:0], sq_ge};
        sq_s    <= {sq_s[61:0], 2'b00};
      end
      DP_DMUL: prod_lo <= mul_p;
      DP_DINIT: begin
        dv <= prod_lo;
        dr <= '0;
      end
      DP_DIV: begin
        dr <= dv_ge ? 32'(dv_t - {1'b0, len}) : dv_t[31:0];
        dv <= {dv[62:0], dv_ge};
      end
      DP_DEND: w[cmd.axis] <= wa[31] ? 32'(-dv[31:0]) : dv[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel[0] <= '0;
      vel[1] <= '0;
      vel[2] <= '0;
    end else if (cmd.op == DP_COMMIT) begin
      vel[0] <= w[0];
      vel[1] <= w[1];
      vel[2] <= w[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_COMMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_COMMIT) begin
      new_vel_x <= w[0];
      new_vel_y <= w[1];
      new_vel_z <= w[2];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/linear_velocity_integrator_limits.sv -----
// ----------------------------------------------------------------------------
// linear_velocity_integrator_limits
// Euler velocity integration with damping, Z limits and horizontal speed cap.
// ----------------------------------------------------------------------------
// Each accepted item is a force vector; the block returns the updated velocity
// one item at a time. The horizontal speed is scaled down when it exceeds its
// limit. The work is done by one shared 32x32 multiplier for nine scaled
// products, the X and Y squares and the scaling products, the 32-step serial
// square root and, when scaling, a 64-step restoring divide for each of X and
// Y. A finished result sits in an output register, so the next item is taken
// while it waits.
`default_nettype none

module linear_velocity_integrator_limits (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lvil_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [47:0]          force_x,
  input  wire logic signed [47:0]          force_y,
  input  wire logic signed [47:0]          force_z,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [31:0]               new_vel_x,
  output logic signed [31:0]               new_vel_y,
  output logic signed [31:0]               new_vel_z
);
  import lvil_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  lvil_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  lvil_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .status, .cmd
  );

  lvil_dp u_dp (
    .clk, .rst, .cfg, .cmd, .status, .force_x, .force_y, .force_z,
    .out_valid, .out_ready, .new_vel_x, .new_vel_y, .new_vel_z
  );

endmodule

`default_nettype wire

// ----- rtl/lvil_checker.sv -----
// ----------------------------------------------------------------------------
// lvil_checker
// Port-level checks of the velocity integrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lvil_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               pready,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] new_vel_x,
  input wire logic signed [31:0] new_vel_y,
  input wire logic signed [31:0] new_vel_z
);

  // A result held back by the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_vel_x) &&
      $stable(new_vel_y) && $stable(new_vel_z))
    else $error("stalled result changed");

  // Only one item is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while busy");

  // A result never appears in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind linear_velocity_integrator_limits lvil_checker u_lvil_checker (
  .clk, .rst, .pready, .in_valid, .in_ready, .out_valid, .out_ready,
  .new_vel_x, .new_vel_y, .new_vel_z
);

`default_nettype wire
